@@ hdl/ureg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ureg_pkg
// Shared constants, types and helpers of the uart register block: action
// codes, register offsets, status and control bit positions.
// ----------------------------------------------------------------------------
package ureg_pkg;

  // action codes
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;

  // register byte offsets
  localparam logic [12:0] OFS_SR   = 13'h000;
  localparam logic [12:0] OFS_DR   = 13'h004;
  localparam logic [12:0] OFS_BRR  = 13'h008;
  localparam logic [12:0] OFS_CR1  = 13'h00C;
  localparam logic [12:0] OFS_CR2  = 13'h010;
  localparam logic [12:0] OFS_CR3  = 13'h014;
  localparam logic [12:0] OFS_GTPR = 13'h018;

  // status bit positions
  localparam int unsigned ST_CTS  = 9;
  localparam int unsigned ST_LBD  = 8;
  localparam int unsigned ST_TXE  = 7;
  localparam int unsigned ST_TC   = 6;
  localparam int unsigned ST_RXNE = 5;
  localparam int unsigned ST_ORE  = 3;

  localparam int unsigned StW = 10;
  localparam logic [StW-1:0] ST_RESET = 10'h0C0;
  // bits that a status write may clear
  localparam logic [StW-1:0] ST_CLR_MASK = 10'h360;

  // control one bit positions
  localparam int unsigned C1_UE     = 13;
  localparam int unsigned C1_TXEIE  = 7;
  localparam int unsigned C1_TCIE   = 6;
  localparam int unsigned C1_RXNEIE = 5;
  localparam int unsigned C1_RE     = 2;

  localparam logic [31:0] TX_LIMIT = 32'h0000_F000;

  // one-hot register select from the offset decoder
  typedef struct packed {
    logic sr;
    logic dr;
    logic brr;
    logic cr1;
    logic cr2;
    logic cr3;
    logic gtpr;
    logic bad;
  } reg_sel_t;

  // one result transaction
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_ready;
    logic        bad_offset;
  } result_t;

  function automatic logic irq_calc(input logic [31:0] ctrl1, input logic [StW-1:0] status);
    irq_calc = (ctrl1[C1_RXNEIE] & (status[ST_RXNE] | status[ST_ORE]))
             | (ctrl1[C1_TXEIE] & status[ST_TXE])
             | (ctrl1[C1_TCIE] & status[ST_TC]);
  endfunction

endpackage

@@ hdl/ureg_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ureg_decode
// Offset decoder: maps a byte offset to a one-hot register select.
// ----------------------------------------------------------------------------
module ureg_decode import ureg_pkg::*; (
  input  logic [12:0] offset_i,
  output reg_sel_t    sel_o
);

  always_comb begin
    sel_o = '0;
    unique case (offset_i)
      OFS_SR:   sel_o.sr   = 1'b1;
      OFS_DR:   sel_o.dr   = 1'b1;
      OFS_BRR:  sel_o.brr  = 1'b1;
      OFS_CR1:  sel_o.cr1  = 1'b1;
      OFS_CR2:  sel_o.cr2  = 1'b1;
      OFS_CR3:  sel_o.cr3  = 1'b1;
      OFS_GTPR: sel_o.gtpr = 1'b1;
      default:  sel_o.bad  = 1'b1;
    endcase
  end

endmodule

@@ hdl/ureg_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ureg_core
// Register state and combinational update for one transaction.
// ----------------------------------------------------------------------------
module ureg_core import ureg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [1:0]  action_i,
  input  reg_sel_t    sel_i,
  input  logic [31:0] write_data_i,
  input  logic [7:0]  rx_byte_i,
  output result_t     res_o
);

  logic [StW-1:0] status_q, status_d;
  logic [7:0]     rx_data_q, rx_data_d;
  logic [31:0]    baud_q, baud_d;
  logic [31:0]    ctrl1_q, ctrl1_d;
  logic [31:0]    ctrl2_q, ctrl2_d;
  logic [31:0]    ctrl3_q, ctrl3_d;
  logic [31:0]    gtpr_q, gtpr_d;
  logic           irq_q, irq_d;
  logic           recalc;

  always_comb begin
    status_d  = status_q;
    rx_data_d = rx_data_q;
    baud_d    = baud_q;
    ctrl1_d   = ctrl1_q;
    ctrl2_d   = ctrl2_q;
    ctrl3_d   = ctrl3_q;
    gtpr_d    = gtpr_q;
    recalc    = 1'b0;
    res_o     = '0;

    case (action_i)
      ACT_READ: begin
        res_o.bad_offset = sel_i.bad;
        if (sel_i.sr) begin
          recalc          = 1'b1;
          res_o.read_data = {22'd0, status_q};
        end
        if (sel_i.dr) begin
          status_d[ST_RXNE] = 1'b0;
          status_d[ST_TC]   = 1'b0;
          res_o.read_data   = {24'd0, rx_data_q};
        end
        if (sel_i.brr)  res_o.read_data = baud_q;
        if (sel_i.cr1)  res_o.read_data = ctrl1_q;
        if (sel_i.cr2)  res_o.read_data = ctrl2_q;
        if (sel_i.cr3)  res_o.read_data = ctrl3_q;
        if (sel_i.gtpr) res_o.read_data = gtpr_q;
      end
      ACT_WRITE: begin
        res_o.bad_offset = sel_i.bad;
        if (sel_i.sr) begin
          // clear-only bits: a written zero clears, a one keeps
          status_d = (status_q & ~ST_CLR_MASK)
                   | (status_q & write_data_i[StW-1:0] & ST_CLR_MASK);
          recalc   = 1'b1;
        end
        if (sel_i.dr && (write_data_i < TX_LIMIT)) begin
          res_o.tx_valid   = 1'b1;
          res_o.tx_byte    = write_data_i[7:0];
          status_d[ST_TXE] = 1'b1;
          status_d[ST_TC]  = 1'b1;
        end
        if (sel_i.brr) baud_d = write_data_i;
        if (sel_i.cr1) begin
          ctrl1_d = write_data_i;
          recalc  = 1'b1;
        end
        if (sel_i.cr2)  ctrl2_d = write_data_i;
        if (sel_i.cr3)  ctrl3_d = write_data_i;
        if (sel_i.gtpr) gtpr_d  = write_data_i;
      end
      ACT_RX: begin
        rx_data_d = rx_byte_i;
        if (ctrl1_q[C1_UE] && ctrl1_q[C1_RE]) begin
          status_d[ST_RXNE] = 1'b1;
          recalc            = 1'b1;
        end
      end
      default: ;
    endcase

    irq_d          = recalc ? irq_calc(ctrl1_d, status_d) : irq_q;
    res_o.irq_out  = irq_d;
    res_o.rx_ready = ~status_d[ST_RXNE];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= ST_RESET;
      rx_data_q <= '0;
      baud_q    <= '0;
      ctrl1_q   <= '0;
      ctrl2_q   <= '0;
      ctrl3_q   <= '0;
      gtpr_q    <= '0;
      irq_q     <= 1'b0;
    end else if (en_i) begin
      status_q  <= status_d;
      rx_data_q <= rx_data_d;
      baud_q    <= baud_d;
      ctrl1_q   <= ctrl1_d;
      ctrl2_q   <= ctrl2_d;
      ctrl3_q   <= ctrl3_d;
      gtpr_q    <= gtpr_d;
      irq_q     <= irq_d;
    end
  end

endmodule

@@ hdl/uart_register_block.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_block
// Register model of a simple uart: status, data, baud, three control and
// guard/prescale registers plus a stored interrupt level.
// ----------------------------------------------------------------------------
// Usage
//   input channel (in_valid_i / in_ready_o): one transaction per bus read,
//   bus write or received character, selected by action_i.
//   output channel (out_valid_o / out_ready_i): exactly one result
//   transaction per input transaction, in order.
//   path: an accepted transaction passes the input register, then the
//   result register, which drives the output.
//   throughput: one transaction per cycle while the receiver takes every
//   result; the whole register update runs in the single combinational
//   step between the two registers.
//   a full result register that is taken in the same cycle frees the path,
//   so the input keeps flowing while the receiver takes every result.
//   receiver stall: the result holds, the input register holds, and
//   in_ready_o drops once both are full; no transaction is lost.
//   reset: both pipeline registers empty, status reads 0xC0 (TXE, TC set),
//   every other register and the interrupt level are zero.
// ----------------------------------------------------------------------------
module uart_register_block import ureg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [12:0] offset_i,
  input  logic [31:0] write_data_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        irq_out_o,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        rx_ready_o,
  output logic        bad_offset_o
);

  // input register
  logic        in_vld_q;
  logic [1:0]  action_q;
  logic [12:0] offset_q;
  logic [31:0] wdata_q;
  logic [7:0]  rbyte_q;

  // result register
  logic        out_vld_q;
  result_t     res_q;
  result_t     res_d;

  reg_sel_t    sel;
  logic        advance;   // the held transaction moves into the result register

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q <= action_i;
      offset_q <= offset_i;
      wdata_q  <= write_data_i;
      rbyte_q  <= rx_byte_i;
    end
  end

  ureg_decode u_decode (
    .offset_i (offset_q),
    .sel_o    (sel)
  );

  // state update happens only when the transaction is committed
  ureg_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .action_i     (action_q),
    .sel_i        (sel),
    .write_data_i (wdata_q),
    .rx_byte_i    (rbyte_q),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign read_data_o  = res_q.read_data;
  assign irq_out_o    = res_q.irq_out;
  assign tx_valid_o   = res_q.tx_valid;
  assign tx_byte_o    = res_q.tx_byte;
  assign rx_ready_o   = res_q.rx_ready;
  assign bad_offset_o = res_q.bad_offset;

endmodule
